>>> hw/rtl/sfd_pkg.sv
// Shared types, codes and constants of the sync-frame deframer.
// No dependencies; imported by every module of the deframer.

package sfd_pkg;

  localparam int unsigned CNT_W = 17;

  localparam logic [7:0]       SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]       SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0]      MAX_LEN_RST     = 16'd256;
  localparam logic [15:0]      CRC_INIT        = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY        = 16'hA001;
  localparam logic [CNT_W-1:0] HDR_BYTES       = CNT_W'(6);
  localparam logic [CNT_W-1:0] MIN_FRAME_BYTES = CNT_W'(8);

  typedef enum logic [2:0] {
    CFG_SYNC_FIRST  = 3'd0,
    CFG_SYNC_SECOND = 3'd1,
    CFG_MAX_LEN     = 3'd2,
    CFG_FAULT_CLEAR = 3'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_OVERSIZE  = 3'd3,
    KIND_TRUNCATED = 3'd4
  } item_kind_e;

  typedef enum logic [10:0] {
    PH_HUNT    = 11'b000_0000_0001,
    PH_SYNC2   = 11'b000_0000_0010,
    PH_ID      = 11'b000_0000_0100,
    PH_SEQ     = 11'b000_0000_1000,
    PH_LENLO   = 11'b000_0001_0000,
    PH_LENHI   = 11'b000_0010_0000,
    PH_PAYLOAD = 11'b000_0100_0000,
    PH_CRCLO   = 11'b000_1000_0000,
    PH_CRCHI   = 11'b001_0000_0000,
    PH_OVWAIT  = 11'b010_0000_0000,
    PH_DISCARD = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } sfd_cfg_t;

  typedef struct packed {
    logic        have;
    item_kind_e  kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  msg_id;
    logic [7:0]  seq;
    logic [15:0] len;
    logic        fault;
  } sfd_result_t;

endpackage

>>> hw/rtl/sfd_crc16_byte.sv
// Byte-wide CRC-16/Modbus update (reflected poly, LSB first).
// Depends on sfd_pkg for the polynomial.

module sfd_crc16_byte
  import sfd_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

>>> hw/rtl/sfd_parser.sv
// Frame parser: phase machine, header fields, running CRC and fault flag.
// Depends on sfd_pkg and sfd_crc16_byte.

module sfd_parser
  import sfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        buf_end_i,
  input  sfd_cfg_t    cfg_i,
  input  logic        fault_clr_i,
  output sfd_result_t res_o
);

  phase_e           ph_q, ph_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       seq_q, seq_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic             fault_q, fault_d;
  logic [15:0]      crc_fed;
  logic [CNT_W-1:0] pay_idx;
  logic             have;
  item_kind_e       kind;
  logic             in_frame;

  sfd_crc16_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_i),
    .crc_o  (crc_fed)
  );

  assign pay_idx = cnt_q - HDR_BYTES;

  always_comb begin
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    id_d     = id_q;
    seq_d    = seq_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    fault_d  = fault_q;
    have     = 1'b0;
    kind     = KIND_PAYLOAD;

    case (ph_q)
      PH_HUNT: begin
        if (byte_i == cfg_i.sync_first) begin
          ph_d  = PH_SYNC2;
          cnt_d = CNT_W'(1);
        end
      end
      PH_SYNC2: begin
        if (byte_i == cfg_i.sync_second) begin
          ph_d  = PH_ID;
          cnt_d = CNT_W'(2);
          crc_d = CRC_INIT;
        end else if (byte_i == cfg_i.sync_first) begin
          cnt_d = CNT_W'(1);
        end else begin
          ph_d = PH_HUNT;
        end
      end
      PH_ID: begin
        id_d  = byte_i;
        crc_d = crc_fed;
        cnt_d = CNT_W'(3);
        ph_d  = PH_SEQ;
      end
      PH_SEQ: begin
        seq_d = byte_i;
        crc_d = crc_fed;
        cnt_d = CNT_W'(4);
        ph_d  = PH_LENLO;
      end
      PH_LENLO: begin
        len_d = {8'h00, byte_i};
        crc_d = crc_fed;
        cnt_d = CNT_W'(5);
        ph_d  = PH_LENHI;
      end
      PH_LENHI: begin
        len_d = {byte_i, len_q[7:0]};
        crc_d = crc_fed;
        cnt_d = HDR_BYTES;
        if (len_d > cfg_i.max_len) begin
          ph_d = PH_OVWAIT;
        end else if (len_d == 16'd0) begin
          ph_d = PH_CRCLO;
        end else begin
          ph_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d = crc_fed;
        cnt_d = cnt_q + CNT_W'(1);
        have  = 1'b1;
        kind  = KIND_PAYLOAD;
        if ((pay_idx + CNT_W'(1)) >= {1'b0, len_q}) begin
          ph_d = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        crc_lo_d = byte_i;
        cnt_d    = cnt_q + CNT_W'(1);
        ph_d     = PH_CRCHI;
      end
      PH_CRCHI: begin
        cnt_d = cnt_q + CNT_W'(1);
        have  = 1'b1;
        if ({byte_i, crc_lo_q} == crc_q) begin
          kind = KIND_GOOD;
        end else begin
          kind    = KIND_CRC_ERR;
          fault_d = 1'b1;
        end
        ph_d = PH_HUNT;
      end
      PH_OVWAIT: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_d >= MIN_FRAME_BYTES) begin
          have    = 1'b1;
          kind    = KIND_OVERSIZE;
          fault_d = 1'b1;
          ph_d    = PH_DISCARD;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        ph_d = PH_HUNT;
      end
    endcase

    // Buffer end abandons a frame in flight; report it only if it got long enough.
    in_frame = (ph_d == PH_ID) || (ph_d == PH_SEQ) || (ph_d == PH_LENLO) ||
               (ph_d == PH_LENHI) || (ph_d == PH_PAYLOAD) || (ph_d == PH_CRCLO) ||
               (ph_d == PH_CRCHI) || (ph_d == PH_OVWAIT);
    if (buf_end_i) begin
      if (in_frame) begin
        have = 1'b0;
        if (cnt_d >= MIN_FRAME_BYTES) begin
          have    = 1'b1;
          kind    = KIND_TRUNCATED;
          fault_d = 1'b1;
        end
      end
      ph_d = PH_HUNT;
    end
  end

  always_comb begin
    res_o.have   = have;
    res_o.kind   = kind;
    res_o.data   = (kind == KIND_PAYLOAD) ? byte_i : 8'h00;
    res_o.index  = (kind == KIND_PAYLOAD) ? pay_idx[15:0] : 16'h0000;
    res_o.msg_id = id_d;
    res_o.seq    = seq_d;
    res_o.len    = len_d;
    res_o.fault  = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_HUNT;
      cnt_q    <= '0;
      id_q     <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      crc_q    <= CRC_INIT;
      crc_lo_q <= '0;
    end else if (step_i) begin
      ph_q     <= ph_d;
      cnt_q    <= cnt_d;
      id_q     <= id_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= 1'b0;
    end else if (fault_clr_i) begin
      fault_q <= 1'b0;
    end else if (step_i) begin
      fault_q <= fault_d;
    end
  end

  a_payload_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ph_q == PH_PAYLOAD) && !buf_end_i |-> res_o.have)
    else $error("payload byte produced no item");

  a_fault_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_clr_i |=> !fault_q)
    else $error("fault flag survived a clear");

endmodule

>>> hw/rtl/sync_frame_deframer_crc16_unit.sv
// Top level of the sync-frame deframer with CRC-16/Modbus check.
// Depends on sfd_pkg, sfd_parser (and through it sfd_crc16_byte).
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+----------------------------------------
//  in       | sink      | in_valid_i/in_ready_o| rx_byte_i, buffer_end_i
//  out      | source    | out_valid_o/out_ready_i | item_kind_o, payload_byte_o, ...
//  cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while out_ready_i is high; an accepted byte yields its item
// (if any) via the input register, then the parser and byte-wide CRC update into the
// result register. Reset clears the parser to sync hunt, CRC to 0xFFFF and the valid
// flags and configuration registers to their defaults. A stalled result register holds
// the input register, which then deasserts in_ready_o; the two stages still fill back to
// back while out_ready_i is high. Configuration transactions are always accepted.

module sync_frame_deframer_crc16_unit
  import sfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        buffer_end_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  message_id_o,
  output logic [7:0]  sequence_number_o,
  output logic [15:0] payload_length_o,
  output logic        protocol_fault_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  sfd_cfg_t    cfg_q;
  logic        cfg_we;
  logic        fault_clr;

  // Input register.
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_end_q;

  // Result register.
  logic        out_valid_q;
  sfd_result_t out_q;

  logic        step;
  sfd_result_t res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign fault_clr   = cfg_we && (cfg_index_i == CFG_FAULT_CLEAR) && cfg_data_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.max_len     <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data_i[7:0];
        CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data_i[7:0];
        CFG_MAX_LEN:     cfg_q.max_len     <= cfg_data_i;
        default: begin
          // fault clear acts on the parser; unknown indexes drop the write
        end
      endcase
    end
  end

  // Advance the parser whenever the input register holds a byte and the
  // result register is free or being emptied this cycle.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset; load only on a transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
      in_end_q  <= buffer_end_i;
    end
  end

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .buf_end_i   (in_end_q),
    .cfg_i       (cfg_q),
    .fault_clr_i (fault_clr),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res.have;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.have) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign item_kind_o       = out_q.kind;
  assign payload_byte_o    = out_q.data;
  assign payload_index_o   = out_q.index;
  assign message_id_o      = out_q.msg_id;
  assign sequence_number_o = out_q.seq;
  assign payload_length_o  = out_q.len;
  assign protocol_fault_o  = out_q.fault;

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q && $stable(in_byte_q))
    else $error("input register lost a byte while the result was stalled");

  a_error_sets_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ((out_q.kind == KIND_CRC_ERR) || (out_q.kind == KIND_OVERSIZE) ||
                    (out_q.kind == KIND_TRUNCATED)) |-> out_q.fault)
    else $error("error status without fault flag");

  a_status_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind != KIND_PAYLOAD) |->
      (out_q.data == 8'h00) && (out_q.index == 16'h0000))
    else $error("status item carries payload data");

endmodule
